/* rtl/four_level_page_table_walker_core_assert.svh */
// Assertion macros for the page table walker core.
// Depends on a clock named clock and a reset named reset in the including module.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property while out of reset.
`define PTW4_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property at every edge, reset included.
`define PTW4_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define PTW4_ASSERT(label, prop, msg)
`define PTW4_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

/* rtl/ptw4_pkg.sv */
// Constants and types for the four-level page table walker.
// No dependencies; imported by the walker core.
package ptw4_pkg;

   // Table store geometry and walk depth
   localparam int TABLE_WORDS = 4096;
   localparam int WALK_LEVELS = 4;
   localparam int ADDR_W      = $clog2(TABLE_WORDS);
   localparam int LVL_W       = $clog2(WALK_LEVELS);

   // Field widths
   localparam int ENTRY_W   = 64;
   localparam int INDEX_W   = 12;
   localparam int VA_W      = 48;
   localparam int LEVEL_W   = 2;
   localparam int TABLE_W   = ENTRY_W - 3;
   localparam int WORD_W    = TABLE_W + 1;
   localparam int SHIFT_W   = 7;

   // Page table entry layout
   localparam int PAGE_SHIFT  = 12;
   localparam int IDX_BITS    = 9;
   localparam int PRESENT_BIT = 0;
   localparam int LARGE_BIT   = 7;
   localparam logic [INDEX_W-1:0] ROOT_ALIGN_MASK = 12'h1FF;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_DATA_W-1:0] FLAG_MASK_RESET = 64'hFFF;

   // Opcodes
   localparam logic OP_WRITE     = 1'b0;
   localparam logic OP_TRANSLATE = 1'b1;

   // Register indexes
   localparam logic REG_ROOT_BASE = 1'b0;
   localparam logic REG_FLAG_MASK = 1'b1;

   typedef logic [ENTRY_W-1:0] entry_type;
   typedef logic [VA_W-1:0]    vaddr_type;

endpackage

/* rtl/four_level_page_table_walker_core.sv */
// Page table walker core: table store, walk sequencer, result register, config port.
// Depends on ptw4_pkg and four_level_page_table_walker_core_assert.svh.
//
// Usage:
//  - req channel carries one item: opcode 0 writes entry_data into the table store at
//    entry_index; opcode 1 translates virtual_address by walking from root_table_base.
//  - rsp channel returns exactly one item per request: fault, physical_address,
//    entry_flags and page_level (all zero for a write).
//  - Registers root_table_base (address 0x0) and flag_mask (address 0x8) sit on the
//    APB-style port; writes complete in the access cycle, pready is always high.
//  - A write item passes through the write state before the next accept. A translate
//    item visits a lookup state (index compute and memory read), then a check state
//    (entry check), for each table level visited, up to four levels. The single table
//    store read port, one dependent read per level, sets this pace.
//  - One item is worked at a time; the next item is accepted as soon as the previous
//    result sits in the output register, even while that result is still stalled.
//  - If rsp_stall holds a result and a new one finishes, the walk holds in place and
//    req_stall stays high until the output register frees.
//  - After reset the table store is cleared one word per cycle, all 4096 words, while
//    req_stall is high. Configuration writes are taken during this pass.
module four_level_page_table_walker_core (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [ptw4_pkg::INDEX_W-1:0]  req_entry_index,
   input  ptw4_pkg::entry_type           req_entry_data,
   input  ptw4_pkg::vaddr_type           req_virtual_address,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_fault,
   output ptw4_pkg::entry_type           rsp_physical_address,
   output ptw4_pkg::entry_type           rsp_entry_flags,
   output logic [ptw4_pkg::LEVEL_W-1:0]  rsp_page_level,
   // configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ptw4_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ptw4_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ptw4_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready
);
   import ptw4_pkg::*;

`include "four_level_page_table_walker_core_assert.svh"

   // Sequencer state codes
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_WRITE  = 3'd2;
   localparam logic [2:0] ST_LOOKUP = 3'd3;
   localparam logic [2:0] ST_CHECK  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [ADDR_W-1:0]   clr_cnt_ff, clr_cnt_in;

   // configuration registers
   logic [INDEX_W-1:0]  root_base_ff, root_base_in;
   entry_type           flag_mask_ff, flag_mask_in;

   // captured item
   logic                opcode_ff;
   logic [INDEX_W-1:0]  entry_index_ff;
   entry_type           entry_data_ff;
   vaddr_type           va_ff;

   // walk state
   logic [TABLE_W-1:0]  table_ff, table_in;
   logic [LVL_W-1:0]    level_ff, level_in;

   // table store
   entry_type           store_mem [TABLE_WORDS];
   entry_type           rd_data_ff;
   logic                mem_we, mem_re;
   logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
   entry_type           mem_wdata;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_fault_ff;
   entry_type           rsp_pa_ff;
   entry_type           rsp_flags_ff;
   logic [LEVEL_W-1:0]  rsp_level_ff;

   logic                res_load;
   logic                res_fault;
   entry_type           res_pa;
   entry_type           res_flags;
   logic [LEVEL_W-1:0]  res_level;

   // datapath helpers
   logic                out_free;
   logic                accept;
   logic                cfg_write;
   logic [SHIFT_W-1:0]  shift_amt;
   entry_type           va_ext;
   logic [IDX_BITS-1:0] lvl_index;
   logic [WORD_W-1:0]   word_addr;
   logic                word_oob;
   logic                write_in_range;
   entry_type           page_offset;
   entry_type           entry_addr;
   logic                ent_present;
   logic                ent_large;
   logic                lvl_last;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Configuration port: one register per 8-byte slot, low address bits ignored
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign prdata    = (paddr[3] == REG_FLAG_MASK) ? flag_mask_ff
                                                  : CSR_DATA_W'(root_base_ff);

   always_comb begin
      root_base_in = root_base_ff;
      flag_mask_in = flag_mask_ff;
      if (cfg_write) begin
         if (paddr[3] == REG_ROOT_BASE) begin
            root_base_in = pwdata[INDEX_W-1:0];
         end else begin
            flag_mask_in = pwdata;
         end
      end
   end

   // Level index and page offset from the captured virtual address
   assign va_ext      = ENTRY_W'(va_ff);
   assign shift_amt   = SHIFT_W'(PAGE_SHIFT) + SHIFT_W'(IDX_BITS) * SHIFT_W'(level_ff);
   assign lvl_index   = IDX_BITS'(va_ext >> shift_amt);
   assign page_offset = va_ext & ((ENTRY_W'(1) << shift_amt) - ENTRY_W'(1));

   // Word address of the selected entry and its store bound check
   assign word_addr = WORD_W'(table_ff) + WORD_W'(lvl_index);
   assign word_oob  = (word_addr >= WORD_W'(TABLE_WORDS));

   // Entry decode on the registered read data
   assign entry_addr  = rd_data_ff & ~flag_mask_ff;
   assign ent_present = rd_data_ff[PRESENT_BIT];
   assign ent_large   = rd_data_ff[LARGE_BIT];
   assign lvl_last    = (level_ff == '0);

   assign write_in_range = (32'(entry_index_ff) < 32'(TABLE_WORDS));

   // Root table base with its low nine bits dropped
   function automatic logic [INDEX_W-1:0] req_root_aligned();
      return root_base_ff & ~ROOT_ALIGN_MASK;
   endfunction

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      table_in   = table_ff;
      level_in   = level_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_waddr  = ADDR_W'(entry_index_ff);
      mem_wdata  = entry_data_ff;
      mem_raddr  = word_addr[ADDR_W-1:0];
      res_load   = 1'b0;
      res_fault  = 1'b0;
      res_pa     = '0;
      res_flags  = '0;
      res_level  = LEVEL_W'(level_ff);
      case (state_ff)
         ST_CLEAR: begin
            // zero one word per cycle
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
            mem_wdata = '0;
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            if (clr_cnt_ff == ADDR_W'(TABLE_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               table_in = TABLE_W'(req_root_aligned());
               level_in = LVL_W'(WALK_LEVELS - 1);
               state_in = (req_opcode == OP_TRANSLATE) ? ST_LOOKUP : ST_WRITE;
            end
         end
         ST_WRITE: begin
            // store the entry and report a zero result together
            if (out_free) begin
               mem_we    = write_in_range;
               res_load  = 1'b1;
               res_level = '0;
               state_in  = ST_IDLE;
            end
         end
         ST_LOOKUP: begin
            if (word_oob) begin
               if (out_free) begin
                  res_load  = 1'b1;
                  res_fault = 1'b1;
                  res_pa    = '1;
                  state_in  = ST_IDLE;
               end
            end else begin
               mem_re   = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!ent_present) begin
               if (out_free) begin
                  res_load  = 1'b1;
                  res_fault = 1'b1;
                  res_pa    = '1;
                  state_in  = ST_IDLE;
               end
            end else if (ent_large || lvl_last) begin
               if (out_free) begin
                  res_load  = 1'b1;
                  res_pa    = entry_addr + page_offset;
                  res_flags = rd_data_ff & flag_mask_ff;
                  state_in  = ST_IDLE;
               end
            end else begin
               // descend to the next table
               table_in = entry_addr[ENTRY_W-1:3];
               level_in = level_ff - LVL_W'(1);
               state_in = ST_LOOKUP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = res_load || (rsp_valid_ff && rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         root_base_ff <= '0;
         flag_mask_ff <= FLAG_MASK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         root_base_ff <= root_base_in;
         flag_mask_ff <= flag_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: capture item, advance walk, hold result
   always_ff @(posedge clock) begin
      if (accept) begin
         opcode_ff      <= req_opcode;
         entry_index_ff <= req_entry_index;
         entry_data_ff  <= req_entry_data;
         va_ff          <= req_virtual_address;
      end
      table_ff <= table_in;
      level_ff <= level_in;
      if (res_load) begin
         rsp_fault_ff <= res_fault;
         rsp_pa_ff    <= res_pa;
         rsp_flags_ff <= res_flags;
         rsp_level_ff <= res_level;
      end
   end

   // Table store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[mem_raddr];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_fault            = rsp_fault_ff;
   assign rsp_physical_address = rsp_pa_ff;
   assign rsp_entry_flags      = rsp_flags_ff;
   assign rsp_page_level       = rsp_level_ff;

   // Assertions
   `PTW4_ASSERT_ALWAYS(a_reset_clears, reset |=> (state_ff == ST_CLEAR),
      "reset must start clear pass")
   `PTW4_ASSERT(a_store_write_state,
      mem_we |-> (state_ff == ST_WRITE || state_ff == ST_CLEAR),
      "store written outside write or clear")
   `PTW4_ASSERT(a_fault_payload,
      (rsp_valid_ff && rsp_fault_ff) |-> (rsp_flags_ff == '0 && rsp_pa_ff == '1),
      "fault result payload wrong")
   `PTW4_ASSERT(a_level_descend,
      (state_ff == ST_CHECK && state_in == ST_LOOKUP)
         |=> (level_ff == $past(level_ff) - LVL_W'(1)),
      "walk level did not step down")
   `PTW4_ASSERT(a_no_overwrite, res_load |-> out_free, "result loaded over a stalled result")
   `PTW4_ASSERT(a_write_op, (state_ff == ST_WRITE) |-> (opcode_ff == OP_WRITE),
      "write state without write opcode")

endmodule
